// ----- hw/rtl/hlpa_pkg.sv -----
package hlpa_pkg;

  // Record parse phases
  typedef enum logic [3:0] {
    PH_HDR,
    PH_TYPE,
    PH_CNT_HI,
    PH_CNT_LO,
    PH_SZ_HI,
    PH_SZ_LO,
    PH_BODY,
    PH_DONE,
    PH_REJECT
  } phase_t;

  // What the back end has to produce for one queue entry
  typedef enum logic [1:0] {
    K_NONE,
    K_BYTE,
    K_START
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int LEN_W = 12;
  localparam int SUM_W = 18;

  localparam logic [LEN_W-1:0] POS_BYTE1        = 12'd1;
  localparam logic [LEN_W-1:0] POS_BYTE2        = 12'd2;
  localparam logic [LEN_W-1:0] POS_PREFIX_SIZE  = 12'd21;
  localparam logic [LEN_W-1:0] POS_ARRAY_COUNT  = 12'd22;
  localparam logic [LEN_W-1:0] MIN_RECORD_BYTES = 12'd23;

  localparam logic [SUM_W-1:0] PARAM_BUFFER_BYTES = 18'd2048;
  localparam logic [SUM_W-1:0] START_CODE_BYTES   = 18'd4;

  localparam logic [5:0] NAL_VPS = 6'h20;
  localparam logic [5:0] NAL_SPS = 6'h21;
  localparam logic [5:0] NAL_PPS = 6'h22;

  localparam logic [7:0] START_CODE_ZERO = 8'h00;
  localparam logic [7:0] START_CODE_ONE  = 8'h01;
  localparam logic [1:0] START_CODE_LAST = 2'd3;

endpackage

// ----- hw/rtl/hlpa_if.sv -----
interface hlpa_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output cmd, output data_byte, output last, input ready);
  modport sink (input valid, input cmd, input data_byte, input last, output ready);
endinterface

interface hlpa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- hw/rtl/hlpa_front.sv -----
module hlpa_front
  import hlpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LEN_W-1:0]   cfg_wr_data,
  hlpa_in_if.sink            in_ch,
  input  fifo_status_t       fifo_st,
  output logic               push,
  output entry_t             push_entry
);

  logic [LEN_W-1:0] rec_len_r, rec_len_nxt;
  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             accepted_r, accepted_nxt;
  logic [2:0]       prefix_size_r, prefix_size_nxt;
  logic [7:0]       arrays_r, arrays_nxt;
  logic [15:0]      units_r, units_nxt;
  logic [5:0]       unit_type_r, unit_type_nxt;
  logic             keep_r, keep_nxt;
  logic [2:0]       pbs_r, pbs_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      payload_r, payload_nxt;
  logic [LEN_W-1:0] emitted_r, emitted_nxt;

  logic             fire;
  logic [LEN_W:0]   next_pos;
  logic [31:0]      pl;
  logic [SUM_W-1:0] rec_sum;
  logic [SUM_W-1:0] buf_sum;
  logic [31:0]      acc_shift;
  logic [2:0]       pbs_inc;
  kind_t            kind;

  function automatic phase_t enter_array(input logic [7:0] arrays,
                                         input logic [LEN_W:0] nxt,
                                         input logic [LEN_W-1:0] len);
    phase_t ph;
    if (arrays == 8'd0 || ({1'b0, nxt} + 14'd3) > {2'b00, len}) begin
      ph = PH_DONE;
    end else begin
      ph = PH_TYPE;
    end
    return ph;
  endfunction

  function automatic phase_t enter_unit(input logic [15:0] units,
                                        input logic [7:0] arrays,
                                        input logic [LEN_W:0] nxt,
                                        input logic [LEN_W-1:0] len);
    phase_t ph;
    if (units == 16'd0) begin
      ph = enter_array(arrays, nxt, len);
    end else if (({1'b0, nxt} + 14'd2) > {2'b00, len}) begin
      ph = PH_DONE;
    end else begin
      ph = PH_SZ_HI;
    end
    return ph;
  endfunction

  assign in_ch.ready = !fifo_st.full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign next_pos    = {1'b0, pos_r} + 13'd1;
  assign pl          = payload_r | {24'd0, in_ch.data_byte};
  assign rec_sum     = {5'd0, next_pos} + {2'b00, pl[15:0]};
  assign buf_sum     = {6'd0, emitted_r} + START_CODE_BYTES + {2'b00, pl[15:0]};
  assign acc_shift   = {acc_r[23:0], in_ch.data_byte};
  assign pbs_inc     = pbs_r + 3'd1;

  always_comb begin
    rec_len_nxt     = cfg_wr_en ? cfg_wr_data : rec_len_r;
    phase_nxt       = phase_r;
    pos_nxt         = pos_r;
    accepted_nxt    = accepted_r;
    prefix_size_nxt = prefix_size_r;
    arrays_nxt      = arrays_r;
    units_nxt       = units_r;
    unit_type_nxt   = unit_type_r;
    keep_nxt        = keep_r;
    pbs_nxt         = pbs_r;
    acc_nxt         = acc_r;
    payload_nxt     = payload_r;
    emitted_nxt     = emitted_r;
    kind            = K_NONE;

    if (fire && !in_ch.cmd && !accepted_r) begin
      if (pos_r >= rec_len_r) begin
        // past the record length: only last matters
        if (in_ch.last) begin
          pos_nxt = '0;
        end
      end else begin
        if (pos_r == '0) begin
          phase_nxt   = (rec_len_r >= MIN_RECORD_BYTES) ? PH_HDR : PH_REJECT;
          keep_nxt    = (in_ch.data_byte != 8'd0);
          emitted_nxt = '0;
        end
        case (phase_nxt)
          PH_HDR: begin
            // keep_nxt doubles as "not a start code" for the first bytes
            if (pos_r == POS_BYTE1 && in_ch.data_byte != 8'd0) begin
              keep_nxt = 1'b1;
            end
            if (pos_r == POS_BYTE2 && !keep_nxt && in_ch.data_byte <= 8'd1) begin
              phase_nxt = PH_REJECT;
            end
            if (pos_r == POS_PREFIX_SIZE) begin
              prefix_size_nxt = {1'b0, in_ch.data_byte[1:0]} + 3'd1;
            end
            if (pos_r == POS_ARRAY_COUNT) begin
              arrays_nxt = in_ch.data_byte;
              phase_nxt  = enter_array(in_ch.data_byte, next_pos, rec_len_r);
            end
          end
          PH_TYPE: begin
            unit_type_nxt = in_ch.data_byte[5:0];
            phase_nxt     = PH_CNT_HI;
          end
          PH_CNT_HI: begin
            units_nxt = {in_ch.data_byte, 8'd0};
            phase_nxt = PH_CNT_LO;
          end
          PH_CNT_LO: begin
            units_nxt  = units_r | {8'd0, in_ch.data_byte};
            arrays_nxt = arrays_r - 8'd1;
            phase_nxt  = enter_unit(units_nxt, arrays_nxt, next_pos, rec_len_r);
          end
          PH_SZ_HI: begin
            payload_nxt = {16'd0, in_ch.data_byte, 8'd0};
            phase_nxt   = PH_SZ_LO;
          end
          PH_SZ_LO: begin
            payload_nxt = pl;
            units_nxt   = units_r - 16'd1;
            if (rec_sum > {6'd0, rec_len_r}) begin
              phase_nxt = PH_DONE;
            end else begin
              keep_nxt = (unit_type_r == NAL_VPS || unit_type_r == NAL_SPS ||
                          unit_type_r == NAL_PPS) && (buf_sum < PARAM_BUFFER_BYTES);
              if (keep_nxt) begin
                kind        = K_START;
                emitted_nxt = buf_sum[LEN_W-1:0];
              end
              if (pl == 32'd0) begin
                phase_nxt = enter_unit(units_nxt, arrays_r, next_pos, rec_len_r);
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            if (keep_r) begin
              kind = K_BYTE;
            end
            payload_nxt = payload_r - 32'd1;
            if (payload_nxt == 32'd0) begin
              phase_nxt = enter_unit(units_r, arrays_r, next_pos, rec_len_r);
            end
          end
          default: ;
        endcase

        if (in_ch.last || next_pos >= {1'b0, rec_len_r}) begin
          if (phase_nxt inside {PH_TYPE, PH_CNT_HI, PH_CNT_LO, PH_SZ_HI, PH_SZ_LO,
                                PH_BODY, PH_DONE}) begin
            accepted_nxt = 1'b1;
            payload_nxt  = '0;
            keep_nxt     = 1'b0;
            pbs_nxt      = '0;
            acc_nxt      = '0;
          end
          pos_nxt = '0;
        end else begin
          pos_nxt = next_pos[LEN_W-1:0];
        end
      end
    end else if (fire && in_ch.cmd && accepted_r) begin
      if (payload_r != 32'd0) begin
        kind        = K_BYTE;
        payload_nxt = payload_r - 32'd1;
      end else if (pbs_inc >= prefix_size_r) begin
        // prefix complete: swap it for a start code unless the unit ends here
        if (!in_ch.last) begin
          kind        = K_START;
          payload_nxt = acc_shift;
        end
        pbs_nxt = '0;
        acc_nxt = '0;
      end else begin
        acc_nxt = acc_shift;
        pbs_nxt = pbs_inc;
      end
      if (in_ch.last) begin
        payload_nxt = '0;
        pbs_nxt     = '0;
        acc_nxt     = '0;
      end
    end
  end

  assign push            = (kind != K_NONE);
  assign push_entry.kind = kind;
  assign push_entry.data = in_ch.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_len_r     <= '0;
      phase_r       <= PH_HDR;
      pos_r         <= '0;
      accepted_r    <= 1'b0;
      prefix_size_r <= 3'd1;
      arrays_r      <= '0;
      units_r       <= '0;
      unit_type_r   <= '0;
      keep_r        <= 1'b0;
      pbs_r         <= '0;
      acc_r         <= '0;
      payload_r     <= '0;
      emitted_r     <= '0;
    end else begin
      rec_len_r     <= rec_len_nxt;
      phase_r       <= phase_nxt;
      pos_r         <= pos_nxt;
      accepted_r    <= accepted_nxt;
      prefix_size_r <= prefix_size_nxt;
      arrays_r      <= arrays_nxt;
      units_r       <= units_nxt;
      unit_type_r   <= unit_type_nxt;
      keep_r        <= keep_nxt;
      pbs_r         <= pbs_nxt;
      acc_r         <= acc_nxt;
      payload_r     <= payload_nxt;
      emitted_r     <= emitted_nxt;
    end
  end

endmodule

// ----- hw/rtl/hlpa_fifo.sv -----
module hlpa_fifo
  import hlpa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  entry_t       push_entry,
  input  logic         pop,
  output entry_t       pop_entry,
  output fifo_status_t st
);

  entry_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign st.full   = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign st.empty  = (count_r == '0);
  assign do_push   = push && !st.full;
  assign do_pop    = pop && !st.empty;
  assign pop_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + FIFO_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/hlpa_emit.sv -----
module hlpa_emit
  import hlpa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  fifo_status_t fifo_st,
  input  entry_t       pop_entry,
  output logic         pop,
  hlpa_out_if.source   out_ch
);

  entry_t     cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       is_final;
  logic       done_cur;
  logic       load;

  assign is_final = (cur_r.kind == K_BYTE) || (idx_r == START_CODE_LAST);
  assign done_cur = cur_valid_r && out_ch.ready && is_final;
  assign load     = !cur_valid_r || done_cur;
  assign pop      = load && !fifo_st.empty;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      // refill straight away so bytes leave back to back
      cur_nxt       = pop_entry;
      cur_valid_nxt = !fifo_st.empty;
      idx_nxt       = '0;
    end else if (cur_valid_r && out_ch.ready) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  assign out_ch.valid    = cur_valid_r;
  assign out_ch.run_last = is_final;
  always_comb begin
    if (cur_r.kind == K_BYTE) begin
      out_ch.out_byte = cur_r.data;
    end else if (idx_r == START_CODE_LAST) begin
      out_ch.out_byte = START_CODE_ONE;
    end else begin
      out_ch.out_byte = START_CODE_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// ----- hw/rtl/hevc_length_prefix_to_annexb.sv -----
// Converts an HEVC configuration record plus length-prefixed access units into a
// start-code byte stream. One input byte is taken per cycle while the queue has
// room; each byte yields nothing, one output byte, or a four-byte 00 00 00 01
// start code. The parser handles each byte as it is accepted and drops its results
// into a four-entry queue; the output side drains one byte per cycle while the
// receiver is ready, so a start code holds the output for four bytes, and input
// stalls only once the queue is full. Program record_length through
// cfg_wr_en/cfg_wr_data while idle.
module hevc_length_prefix_to_annexb
  import hlpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  hlpa_in_if.sink          in_ch,
  hlpa_out_if.source       out_ch
);

  fifo_status_t fifo_st;
  logic         push;
  entry_t       push_entry;
  logic         pop;
  entry_t       pop_entry;

  hlpa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .fifo_st    (fifo_st),
    .push       (push),
    .push_entry (push_entry)
  );

  hlpa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .pop_entry (pop_entry),
    .st        (fifo_st)
  );

  hlpa_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .fifo_st  (fifo_st),
    .pop_entry(pop_entry),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // never take a transaction the queue cannot hold
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && fifo_st.full))
    else $error("input accepted with queue full");

  // a queued result is visible next cycle, either in the queue or at the output
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_ch.valid && in_ch.ready |=> !fifo_st.empty || out_ch.valid)
    else $error("queued result lost");

  // nothing is presented straight after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import hlpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_UNIT   = 1'b1
  } cmd_t;

  typedef enum {
    AU_NORMAL,
    AU_OVERLONG,
    AU_SHORT_TAIL,
    AU_NOISE
  } au_kind_t;

  typedef enum {
    RX_STREAM,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_t;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    cmd_t       cmd;
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
  } stream_byte_t;

  localparam logic [5:0] NAL_SEI_PREFIX = 6'h27;
  localparam int RANDOM_ITEMS   = 120;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  hlpa_in_if  in_ch ();
  hlpa_out_if out_ch ();

  hevc_length_prefix_to_annexb u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5 clk = ~clk;

  byte_item_t   pending_items[$];
  stream_byte_t annexb_due[$];
  logic [7:0]   staged[$];

  // converter state as seen from outside
  logic [LEN_W-1:0] rec_len_cfg    = '0;
  phase_t           parse_phase    = PH_HDR;
  int unsigned      rec_pos        = 0;
  logic             rec_done       = 1'b0;
  logic [2:0]       unit_pfx_size  = 3'd1;
  logic [7:0]       arrays_left    = '0;
  logic [15:0]      units_left     = '0;
  logic [5:0]       unit_nal       = '0;
  logic             keep_unit      = 1'b0;
  int unsigned      pfx_seen       = 0;
  logic [31:0]      len_acc        = '0;
  logic [31:0]      pay_left       = '0;
  logic [31:0]      param_bytes    = '0;

  int         pfx_bytes  = 1;
  int         mismatches = 0;
  int         bytes_in   = 0;
  int         bytes_out  = 0;
  int         holds      = 0;
  logic       hold_ask   = 1'b0;
  logic       hold_taken = 1'b0;
  int         hold_left  = 0;
  int         burst_left = 0;
  int         gap_left   = 0;
  int         window_left = 0;
  rx_mode_t   rx_mode    = RX_STREAM;
  int         quiet_cycles = 0;
  byte_item_t next_item;

  function automatic void put_start_code();
    staged.push_back(START_CODE_ZERO);
    staged.push_back(START_CODE_ZERO);
    staged.push_back(START_CODE_ZERO);
    staged.push_back(START_CODE_ONE);
  endfunction

  function automatic void enter_array(input int unsigned next, input int unsigned len);
    if (arrays_left == 0 || next + 3 > len) parse_phase = PH_DONE;
    else parse_phase = PH_TYPE;
  endfunction

  function automatic void enter_unit(input int unsigned next, input int unsigned len);
    if (units_left == 0) enter_array(next, len);
    else if (next + 2 > len) parse_phase = PH_DONE;
    else parse_phase = PH_SZ_HI;
  endfunction

  function automatic void convert_byte(input logic cmd, input logic [7:0] b, input logic last);
    int unsigned  p;
    int unsigned  len;
    stream_byte_t sb;
    staged.delete();
    if (cmd == CMD_RECORD) begin
      len = rec_len_cfg;
      p = rec_pos;
      if (!rec_done) begin
        if (p >= len) begin
          if (last) rec_pos = 0;
        end else begin
          if (p == 0) begin
            parse_phase = (len >= MIN_RECORD_BYTES) ? PH_HDR : PH_REJECT;
            keep_unit = (b != 8'h00);
            param_bytes = '0;
          end
          case (parse_phase)
            PH_HDR: begin
              if (p == POS_BYTE1 && b != 8'h00) keep_unit = 1'b1;
              // a record that opens with a start code is already converted
              if (p == POS_BYTE2 && !keep_unit && b <= START_CODE_ONE) parse_phase = PH_REJECT;
              if (p == POS_PREFIX_SIZE) unit_pfx_size = {1'b0, b[1:0]} + 3'd1;
              if (p == POS_ARRAY_COUNT) begin
                arrays_left = b;
                enter_array(p + 1, len);
              end
            end
            PH_TYPE: begin
              unit_nal = b[5:0];
              parse_phase = PH_CNT_HI;
            end
            PH_CNT_HI: begin
              units_left = {b, 8'h00};
              parse_phase = PH_CNT_LO;
            end
            PH_CNT_LO: begin
              units_left[7:0] = b;
              arrays_left = arrays_left - 8'd1;
              enter_unit(p + 1, len);
            end
            PH_SZ_HI: begin
              pay_left = {16'h0000, b, 8'h00};
              parse_phase = PH_SZ_LO;
            end
            PH_SZ_LO: begin
              pay_left[7:0] = b;
              units_left = units_left - 16'd1;
              if (p + 1 + pay_left > len) begin
                parse_phase = PH_DONE;
              end else begin
                keep_unit = (unit_nal == NAL_VPS || unit_nal == NAL_SPS || unit_nal == NAL_PPS)
                            && (param_bytes + START_CODE_BYTES + pay_left < PARAM_BUFFER_BYTES);
                if (keep_unit) begin
                  put_start_code();
                  param_bytes = param_bytes + START_CODE_BYTES + pay_left;
                end
                if (pay_left == 0) enter_unit(p + 1, len);
                else parse_phase = PH_BODY;
              end
            end
            PH_BODY: begin
              if (keep_unit) staged.push_back(b);
              pay_left = pay_left - 1;
              if (pay_left == 0) enter_unit(p + 1, len);
            end
            default: ;
          endcase
          if (last || p + 1 >= len) begin
            if (parse_phase >= PH_TYPE && parse_phase <= PH_DONE) begin
              rec_done = 1'b1;
              pay_left = '0;
              keep_unit = 1'b0;
              pfx_seen = 0;
              len_acc = '0;
            end
            rec_pos = 0;
          end else begin
            rec_pos = p + 1;
          end
        end
      end
    end else if (rec_done) begin
      if (pay_left != 0) begin
        staged.push_back(b);
        pay_left = pay_left - 1;
      end else begin
        len_acc = {len_acc[23:0], b};
        pfx_seen++;
        if (pfx_seen >= unit_pfx_size) begin
          // a prefix that completes on the final byte has no payload to carry
          if (!last) begin
            put_start_code();
            pay_left = len_acc;
          end
          pfx_seen = 0;
          len_acc = '0;
        end
      end
      if (last) begin
        pay_left = '0;
        pfx_seen = 0;
        len_acc = '0;
      end
    end
    foreach (staged[i]) begin
      sb.data = staged[i];
      sb.run_last = (i == staged.size() - 1);
      annexb_due.push_back(sb);
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void fill_random(ref byte_q_t q, input int n);
    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
  endfunction

  function automatic void add_bytes(input cmd_t cmd, input byte_q_t bytes);
    byte_item_t it;
    foreach (bytes[i]) begin
      it.cmd = cmd;
      it.data = bytes[i];
      it.last = (i == bytes.size() - 1);
      pending_items.push_back(it);
    end
  endfunction

  function automatic void add_array_header(ref byte_q_t q, input logic [5:0] nal,
                                           input int count);
    logic [31:0] rnd;
    rnd = $urandom;
    q.push_back({rnd[1:0], nal});
    q.push_back(8'(count >> 8));
    q.push_back(8'(count));
  endfunction

  function automatic void add_param_unit(ref byte_q_t q, input int len);
    q.push_back(8'(len >> 8));
    q.push_back(8'(len));
    fill_random(q, len);
  endfunction

  function automatic void push_length(ref byte_q_t q, input int len);
    for (int k = pfx_bytes - 1; k >= 0; k--) q.push_back(8'(len >> (8 * k)));
  endfunction

  // first_len below zero picks the first unit's length at random
  function automatic void add_access_unit(input au_kind_t kind, input int first_len,
                                          output int n_items);
    byte_q_t au;
    int      n_units;
    int      plen;
    n_units = $urandom_range(1, 3);
    if (kind == AU_NOISE) begin
      fill_random(au, $urandom_range(1, 16));
    end else begin
      for (int u = 0; u < n_units; u++) begin
        if (u == 0 && first_len >= 0) plen = first_len;
        else plen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
        push_length(au, plen);
        fill_random(au, plen);
      end
      case (kind)
        AU_OVERLONG: begin
          push_length(au, $urandom_range(20, 200));
          fill_random(au, $urandom_range(1, 5));
        end
        AU_SHORT_TAIL: fill_random(au, $urandom_range(1, pfx_bytes));
        default: ;
      endcase
    end
    add_bytes(CMD_UNIT, au);
    n_items = au.size();
  endfunction

  task automatic write_record_length(input logic [LEN_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rec_len_cfg = value;
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || annexb_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= CMD_RECORD;
      in_ch.data_byte <= '0;
      in_ch.last <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        convert_byte(in_ch.cmd, in_ch.data_byte, in_ch.last);
        bytes_in++;
      end
      if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= next_item.cmd;
        in_ch.data_byte <= next_item.data;
        in_ch.last <= next_item.last;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: check each transaction, stall in windows of changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        bytes_out++;
        if (annexb_due.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h run_last %0b",
                                    out_ch.out_byte, out_ch.run_last));
        end else if (annexb_due[0].data !== out_ch.out_byte ||
                     annexb_due[0].run_last !== out_ch.run_last) begin
          report_mismatch($sformatf("mismatch at output byte %0d: expected %02h/%0b, got %02h/%0b",
                                    bytes_out, annexb_due[0].data, annexb_due[0].run_last,
                                    out_ch.out_byte, out_ch.run_last));
          void'(annexb_due.pop_front());
        end else begin
          void'(annexb_due.pop_front());
        end
      end
      if (hold_ask && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
        holds++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (window_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          window_left = $urandom_range(16, 96);
        end else begin
          window_left--;
        end
        case (rx_mode)
          RX_STREAM: out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
          default:   out_ch.ready <= (window_left % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles", quiet_cycles);
        $display("hevc_length_prefix_to_annexb regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    byte_q_t     rec;
    logic [31:0] rnd;
    logic [1:0]  pfx_code;
    int          n;
    int          fed;
    int          pick;
    au_kind_t    kind;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_RECORD;
    in_ch.data_byte = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    pfx_code = 2'($urandom_range(0, 3));
    pfx_bytes = pfx_code + 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // zero length: record bytes ignored; access units dropped before acceptance
    write_record_length('0);
    rec.delete();
    fill_random(rec, 3);
    add_bytes(CMD_RECORD, rec);
    add_access_unit(AU_NOISE, -1, n);
    wait_quiet();

    // too short to hold a header
    write_record_length(MIN_RECORD_BYTES - 12'd1);
    rec = {8'h01};
    fill_random(rec, 21);
    add_bytes(CMD_RECORD, rec);
    wait_quiet();

    // ends inside the header, then two that already carry start codes
    write_record_length('1);
    rec = {8'h01};
    fill_random(rec, 9);
    add_bytes(CMD_RECORD, rec);
    rec = {START_CODE_ZERO, START_CODE_ZERO, START_CODE_ONE};
    fill_random(rec, 27);
    add_bytes(CMD_RECORD, rec);
    rec = {START_CODE_ZERO, START_CODE_ZERO, START_CODE_ZERO};
    fill_random(rec, 27);
    add_bytes(CMD_RECORD, rec);
    wait_quiet();

    // bytes past the programmed length until last
    write_record_length(12'd5);
    rec = {8'h01};
    fill_random(rec, 8);
    add_bytes(CMD_RECORD, rec);
    wait_quiet();

    // the record that gets accepted
    rec = {8'h01};
    fill_random(rec, 20);
    rnd = $urandom;
    rec.push_back({rnd[7:2], pfx_code});
    rec.push_back(8'd6);
    add_array_header(rec, NAL_VPS, 2);
    add_param_unit(rec, 0);
    add_param_unit(rec, 5);
    add_array_header(rec, NAL_SPS, 1);
    add_param_unit(rec, 8);
    add_array_header(rec, NAL_SEI_PREFIX, 1);
    add_param_unit(rec, 3);
    add_array_header(rec, NAL_PPS, 2);
    add_param_unit(rec, 4);
    // 33 bytes kept so far: this unit lands exactly on the budget and is skipped,
    // and last ends the record inside its payload
    rec.push_back(8'((int'(PARAM_BUFFER_BYTES) - 37) >> 8));
    rec.push_back(8'(int'(PARAM_BUFFER_BYTES) - 37));
    fill_random(rec, 10);
    write_record_length(LEN_W'(rec.size() + int'(PARAM_BUFFER_BYTES)));
    add_bytes(CMD_RECORD, rec);
    rec.delete();
    fill_random(rec, 2);
    add_bytes(CMD_RECORD, rec);

    add_access_unit(AU_NORMAL, 0, n);
    add_access_unit(AU_NORMAL, 12, n);
    add_access_unit(AU_OVERLONG, -1, n);
    add_access_unit(AU_SHORT_TAIL, -1, n);
    add_access_unit(AU_NOISE, -1, n);
    wait_quiet();

    fed = 0;
    for (int half = 0; half < 2; half++) begin
      while (fed < (half + 1) * RANDOM_ITEMS / 2) begin
        pick = $urandom_range(0, 19);
        if (pick == 19) begin
          rec.delete();
          fill_random(rec, 1);
          add_bytes(CMD_RECORD, rec);
        end else begin
          kind = (pick < 13) ? AU_NORMAL : (pick < 15) ? AU_OVERLONG :
                 (pick < 17) ? AU_SHORT_TAIL : AU_NOISE;
          add_access_unit(kind, -1, n);
          fed += n;
        end
      end
      if (half == 0) begin
        // drain fully, then show a new length has no effect once accepted
        wait_quiet();
        write_record_length(MIN_RECORD_BYTES);
        rec = {8'h01};
        fill_random(rec, 29);
        add_bytes(CMD_RECORD, rec);
      end else begin
        hold_ask = 1'b1;
      end
    end

    wait_quiet();
    if (annexb_due.size() != 0) mismatches += annexb_due.size();
    $display("covered %0d input bytes (records, access units, ignored and dropped bytes)",
             bytes_in);
    $display("checked %0d output bytes, %0d-byte length prefix, %0d receiver hold-off(s)",
             bytes_out, pfx_bytes, holds);
    if (mismatches == 0) begin
      $display("hevc_length_prefix_to_annexb regression: pass");
    end else begin
      $display("hevc_length_prefix_to_annexb regression: fail");
    end
    $finish;
  end

endmodule
